FILE: rtl/swg_pkg.sv
// Shared constants, types and helper functions of the sliding window generator.
package swg_pkg;

  localparam int unsigned WINDOW_ROWS = 3;
  localparam int unsigned WINDOW_COLS = 3;
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned PIXEL_BITS  = 32;
  localparam int unsigned MAX_HEIGHT  = 1024;

  localparam int unsigned PORT_PIX_W = 32;
  localparam int unsigned STORE_W    = (PIXEL_BITS < PORT_PIX_W) ? PIXEL_BITS : PORT_PIX_W;
  localparam int unsigned TAP_W      = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_REG_W  = 11;
  localparam int unsigned STRIDE_W   = 4;
  localparam int unsigned CD_W       = 4;

  localparam int unsigned DEPTH   = WINDOW_ROWS * MAX_WIDTH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W  = (WINDOW_ROWS > 1) ? $clog2(WINDOW_ROWS) : 1;
  localparam int unsigned WCNT_W  = (WINDOW_COLS > 1) ? $clog2(WINDOW_COLS) : 1;
  localparam int unsigned ROWP_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned WCMP_W  = (COL_W + 1 > DIM_REG_W) ? COL_W + 1 : DIM_REG_W;
  localparam int unsigned HCMP_W  = (ROWP_W + 1 > DIM_REG_W) ? ROWP_W + 1 : DIM_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_STRIDE_ROWS  = 4'd2,
    REG_STRIDE_COLS  = 4'd3
  } swg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } swg_state_e;

  // Next row slot of the circular line store.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == SLOT_W'(WINDOW_ROWS - 1)) begin
      res = '0;
    end else begin
      res = slot + SLOT_W'(1);
    end
    return res;
  endfunction

  // Line store address of a row slot and a column.
  function automatic logic [ADDR_W-1:0] line_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0]  col);
    logic [ADDR_W-1:0] res;
    res = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
    return res;
  endfunction

  // A stride register of zero steps by one.
  function automatic logic [CD_W-1:0] eff_stride(input logic [STRIDE_W-1:0] s);
    logic [CD_W-1:0] res;
    res = (s == '0) ? CD_W'(1) : CD_W'(s);
    return res;
  endfunction

endpackage

FILE: rtl/swg_if.sv
// Channel interfaces of the sliding window generator: pixels, taps and configuration.
interface swg_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

interface swg_tap_if;
  logic        valid;
  logic        ready;
  logic [31:0] tap_pixel;
  logic [1:0]  tap_row;
  logic [1:0]  tap_col;
  logic        last_tap;

  modport source (output valid, output tap_pixel, output tap_row, output tap_col,
                  output last_tap, input ready);
  modport sink (input valid, input tap_pixel, input tap_row, input tap_col,
                input last_tap, output ready);
endinterface

interface swg_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sliding_window_generator_unit.sv
// Sliding window generator: line store writes, window position tracking and tap readout.
// The first tap of a window passes the sequencer registers, the line store read register
// and the output register. A pixel that completes a window holds off later pixels until
// its last tap read issues, one line store read per tap through the single read port.
// Reset: position counters, countdowns and handshakes clear, the configuration registers
// return to their defaults, and the line store keeps its contents (no clearing pass).
module sliding_window_generator_unit import swg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  swg_pixel_if.sink      pix_sink,
  swg_tap_if.source      tap_src,
  swg_cfg_if.sink        cfg_sink
);

  // Configuration registers.
  logic [DIM_REG_W-1:0] frame_width_q, frame_width_d;
  logic [DIM_REG_W-1:0] frame_height_q, frame_height_d;
  logic [STRIDE_W-1:0]  stride_rows_q, stride_rows_d;
  logic [STRIDE_W-1:0]  stride_cols_q, stride_cols_d;

  // Frame position.
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [COL_W-1:0]  col_pos_q, col_pos_d;
  logic [ROWP_W-1:0] row_pos_q, row_pos_d;
  logic [CD_W-1:0]   row_cd_q, row_cd_d;
  logic [CD_W-1:0]   col_cd_q, col_cd_d;

  // Tap readout sequencer.
  swg_state_e        state_q, state_d;
  logic [SLOT_W-1:0] rd_r_q, rd_r_d;
  logic [WCNT_W-1:0] rd_c_q, rd_c_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [COL_W-1:0]  rd_col_q, rd_col_d;
  logic [COL_W-1:0]  col_base_q, col_base_d;

  // Read stage tag and output register.
  logic              rd_vld_q, rd_vld_d;
  logic [TAP_W-1:0]  rd_row_tag_q, rd_row_tag_d;
  logic [TAP_W-1:0]  rd_col_tag_q, rd_col_tag_d;
  logic              rd_last_q, rd_last_d;
  logic              out_vld_q, out_vld_d;
  logic [PORT_PIX_W-1:0] out_pix_q, out_pix_d;
  logic [TAP_W-1:0]  out_row_q, out_row_d;
  logic [TAP_W-1:0]  out_col_q, out_col_d;
  logic              out_last_q, out_last_d;

  logic               pix_xfer, cfg_xfer, emit, issue, last_issue, load_out, pix_ready;
  logic               tap_last_pos;
  logic [WCMP_W-1:0]  eff_w, col_next;
  logic [HCMP_W-1:0]  eff_h, row_next;
  logic [STORE_W-1:0] rd_data;

  swg_line_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (pix_xfer),
    .wr_addr_i (line_addr(wr_slot_q, col_pos_q)),
    .wr_data_i (pix_sink.pixel_word[STORE_W-1:0]),
    .rd_en_i   (issue),
    .rd_addr_i (line_addr(rd_slot_q, rd_col_q)),
    .rd_data_o (rd_data)
  );

  // Handshakes and sequencing.
  always_comb begin
    load_out     = rd_vld_q && (!out_vld_q || tap_src.ready);
    issue        = (state_q == ST_READ) && (!rd_vld_q || load_out);
    tap_last_pos = (rd_r_q == SLOT_W'(WINDOW_ROWS - 1)) && (rd_c_q == WCNT_W'(WINDOW_COLS - 1));
    last_issue   = issue && tap_last_pos;
    pix_ready    = (state_q == ST_IDLE) || last_issue;
    pix_xfer     = pix_sink.valid && pix_ready;
    cfg_xfer     = cfg_sink.valid;
    emit         = (row_pos_q >= ROWP_W'(WINDOW_ROWS - 1)) &&
                   (col_pos_q >= COL_W'(WINDOW_COLS - 1)) &&
                   (row_cd_q == CD_W'(1)) && (col_cd_q == CD_W'(1));
  end

  assign pix_sink.ready    = pix_ready;
  assign cfg_sink.ready    = 1'b1;
  assign tap_src.valid     = out_vld_q;
  assign tap_src.tap_pixel = out_pix_q;
  assign tap_src.tap_row   = out_row_q;
  assign tap_src.tap_col   = out_col_q;
  assign tap_src.last_tap  = out_last_q;

  // Next state of the readout sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pix_xfer && emit) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (last_issue) begin
          state_d = (pix_xfer && emit) ? ST_READ : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Read address walk over the window, row by row.
  always_comb begin
    rd_r_d     = rd_r_q;
    rd_c_d     = rd_c_q;
    rd_slot_d  = rd_slot_q;
    rd_col_d   = rd_col_q;
    col_base_d = col_base_q;
    if (pix_xfer && emit) begin
      rd_r_d     = '0;
      rd_c_d     = '0;
      rd_slot_d  = next_slot(wr_slot_q);
      col_base_d = col_pos_q - COL_W'(WINDOW_COLS - 1);
      rd_col_d   = col_pos_q - COL_W'(WINDOW_COLS - 1);
    end else if (issue) begin
      if (rd_c_q == WCNT_W'(WINDOW_COLS - 1)) begin
        rd_c_d    = '0;
        rd_col_d  = col_base_q;
        rd_r_d    = rd_r_q + SLOT_W'(1);
        rd_slot_d = next_slot(rd_slot_q);
      end else begin
        rd_c_d   = rd_c_q + WCNT_W'(1);
        rd_col_d = rd_col_q + COL_W'(1);
      end
    end
  end

  // Read stage and output register.
  always_comb begin
    rd_vld_d     = rd_vld_q;
    rd_row_tag_d = rd_row_tag_q;
    rd_col_tag_d = rd_col_tag_q;
    rd_last_d    = rd_last_q;
    out_vld_d    = out_vld_q;
    out_pix_d    = out_pix_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_last_d   = out_last_q;
    if (issue) begin
      rd_vld_d     = 1'b1;
      rd_row_tag_d = TAP_W'(rd_r_q);
      rd_col_tag_d = TAP_W'(rd_c_q);
      rd_last_d    = tap_last_pos;
    end else if (load_out) begin
      rd_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d  = 1'b1;
      out_pix_d  = PORT_PIX_W'(rd_data);
      out_row_d  = rd_row_tag_q;
      out_col_d  = rd_col_tag_q;
      out_last_d = rd_last_q;
    end else if (tap_src.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Frame position and configuration.
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    stride_rows_d  = stride_rows_q;
    stride_cols_d  = stride_cols_q;
    wr_slot_d      = wr_slot_q;
    col_pos_d      = col_pos_q;
    row_pos_d      = row_pos_q;
    row_cd_d       = row_cd_q;
    col_cd_d       = col_cd_q;

    if (frame_width_q == '0) begin
      eff_w = WCMP_W'(1);
    end else if (WCMP_W'(frame_width_q) > WCMP_W'(MAX_WIDTH)) begin
      eff_w = WCMP_W'(MAX_WIDTH);
    end else begin
      eff_w = WCMP_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      eff_h = HCMP_W'(1);
    end else if (HCMP_W'(frame_height_q) > HCMP_W'(MAX_HEIGHT)) begin
      eff_h = HCMP_W'(MAX_HEIGHT);
    end else begin
      eff_h = HCMP_W'(frame_height_q);
    end
    col_next = WCMP_W'(col_pos_q) + WCMP_W'(1);
    row_next = HCMP_W'(row_pos_q) + HCMP_W'(1);

    if (cfg_xfer) begin
      unique case (cfg_sink.index)
        REG_FRAME_WIDTH:  frame_width_d  = cfg_sink.data[DIM_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_d = cfg_sink.data[DIM_REG_W-1:0];
        REG_STRIDE_ROWS:  stride_rows_d  = cfg_sink.data[STRIDE_W-1:0];
        REG_STRIDE_COLS:  stride_cols_d  = cfg_sink.data[STRIDE_W-1:0];
        default: ;
      endcase
      // Any register write restarts the frame; stored pixels are kept.
      if (cfg_sink.index == REG_FRAME_WIDTH || cfg_sink.index == REG_FRAME_HEIGHT ||
          cfg_sink.index == REG_STRIDE_ROWS || cfg_sink.index == REG_STRIDE_COLS) begin
        wr_slot_d = '0;
        col_pos_d = '0;
        row_pos_d = '0;
        row_cd_d  = CD_W'(WINDOW_ROWS);
        col_cd_d  = CD_W'(WINDOW_COLS);
      end
    end else if (pix_xfer) begin
      col_cd_d  = (col_cd_q <= CD_W'(1)) ? eff_stride(stride_cols_q) : col_cd_q - CD_W'(1);
      col_pos_d = COL_W'(col_next);
      if (col_next >= eff_w) begin
        col_pos_d = '0;
        col_cd_d  = CD_W'(WINDOW_COLS);
        row_cd_d  = (row_cd_q <= CD_W'(1)) ? eff_stride(stride_rows_q) : row_cd_q - CD_W'(1);
        wr_slot_d = next_slot(wr_slot_q);
        row_pos_d = ROWP_W'(row_next);
        if (row_next >= eff_h) begin
          wr_slot_d = '0;
          row_pos_d = '0;
          row_cd_d  = CD_W'(WINDOW_ROWS);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_REG_W'(32);
      frame_height_q <= DIM_REG_W'(32);
      stride_rows_q  <= STRIDE_W'(1);
      stride_cols_q  <= STRIDE_W'(1);
      wr_slot_q      <= '0;
      col_pos_q      <= '0;
      row_pos_q      <= '0;
      row_cd_q       <= CD_W'(WINDOW_ROWS);
      col_cd_q       <= CD_W'(WINDOW_COLS);
      state_q        <= ST_IDLE;
      rd_r_q         <= '0;
      rd_c_q         <= '0;
      rd_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      stride_rows_q  <= stride_rows_d;
      stride_cols_q  <= stride_cols_d;
      wr_slot_q      <= wr_slot_d;
      col_pos_q      <= col_pos_d;
      row_pos_q      <= row_pos_d;
      row_cd_q       <= row_cd_d;
      col_cd_q       <= col_cd_d;
      state_q        <= state_d;
      rd_r_q         <= rd_r_d;
      rd_c_q         <= rd_c_d;
      rd_vld_q       <= rd_vld_d;
      out_vld_q      <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q    <= rd_slot_d;
    rd_col_q     <= rd_col_d;
    col_base_q   <= col_base_d;
    rd_row_tag_q <= rd_row_tag_d;
    rd_col_tag_q <= rd_col_tag_d;
    rd_last_q    <= rd_last_d;
    out_pix_q    <= out_pix_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    out_last_q   <= out_last_d;
  end

endmodule

FILE: rtl/swg_line_store.sv
// Circular line store: one write port and one enabled read port with registered data.
module swg_line_store import swg_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  logic [STORE_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output logic [STORE_W-1:0] rd_data_o
);

  logic [STORE_W-1:0] mem_q [DEPTH];
  logic [STORE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds while no read is issued, so a stalled tap keeps its word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
